// File: sv/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsfd_pkg;

  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_KEY  = 5'b01000,
    PH_DATA = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RSV      = 3'd1,
    ST_MASK     = 3'd2,
    ST_FRAG     = 3'd3,
    ST_OPCODE   = 3'd4,
    ST_CONTROL  = 3'd5,
    ST_TOO_LONG = 3'd6
  } status_e;

  localparam logic [1:0] REG_MASK_REQUIRED = 2'd0;
  localparam logic [1:0] REG_REJECT_FRAG   = 2'd1;
  localparam logic [1:0] REG_CAPACITY      = 2'd2;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [63:0] CTRL_MAX_LEN = 64'd125;

  // One result beat as it travels through the queue.
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] length;
    logic [2:0]  status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic mask_required;
    logic reject_fragments;
    logic [31:0] capacity;
  } cfg_t;

endpackage

// File: sv/wsfd_parser.sv
// Front end: parse, validate, unmask; one byte per cycle while res_ready_i.
module wsfd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       rx_byte_i,
  input  wsfd_pkg::cfg_t   cfg_i,
  output logic             res_valid_o,
  output wsfd_pkg::result_t res_o,
  input  logic             res_ready_i
);
  import wsfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  hdr0_q, hdr0_d;
  logic        mask_q, mask_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic [31:0] key_q, key_d;
  logic [63:0] rem_q, rem_d;
  logic        drop_q, drop_d;
  logic [1:0]  koff_q, koff_d;

  logic        fire;
  logic [2:0]  status;
  logic        fin;
  logic [3:0]  op;
  logic        finish;
  logic        emit;
  logic [63:0] rem_dec;
  logic [7:0]  key_byte;

  assign in_ready_o = res_ready_i;
  assign fire       = in_valid_i && res_ready_i;
  assign fin        = hdr0_q[7];
  assign op         = hdr0_q[3:0];

  // Header checks on the length as it will be once this byte is taken in.
  function automatic logic [2:0] check(input logic [7:0] h, input logic m,
                                       input logic [63:0] l, input cfg_t c);
    logic       f;
    logic [3:0] o;
    logic [2:0] s;
    f = h[7];
    o = h[3:0];
    if (h[6:4] != 3'd0) s = ST_RSV;
    else if (c.mask_required != m) s = ST_MASK;
    else if (c.reject_fragments && (!f || o == OP_CONT)) s = ST_FRAG;
    else if (!(o == OP_TEXT || o == OP_BINARY || o == OP_CLOSE ||
               o == OP_PING || o == OP_PONG)) s = ST_OPCODE;
    else if (o[3] && (!f || l > CTRL_MAX_LEN || (o == OP_CLOSE && l == 64'd1)))
      s = ST_CONTROL;
    else if (l > {32'd0, c.capacity}) s = ST_TOO_LONG;
    else s = ST_OK;
    return s;
  endfunction

  assign rem_dec  = (rem_q != 64'd0) ? rem_q - 64'd1 : 64'd0;
  assign key_byte = key_q[8*(3-koff_q) +: 8];

  always_comb begin
    phase_d = phase_q; hdr0_d = hdr0_q; mask_d = mask_q; cnt_d = cnt_q;
    len_d = len_q; key_d = key_q; rem_d = rem_q; drop_d = drop_q; koff_d = koff_q;
    finish = 1'b0;
    emit   = 1'b0;
    res_o  = '0;
    if (fire) begin
      unique case (phase_q)
        PH_HDR0: begin
          hdr0_d = rx_byte_i; mask_d = 1'b0; len_d = '0; key_d = '0;
          cnt_d = '0; phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          mask_d = rx_byte_i[7];
          cnt_d  = '0;
          if (rx_byte_i[6:0] == LEN_EXT16 || rx_byte_i[6:0] == LEN_EXT64) begin
            len_d   = '0;
            cnt_d   = (rx_byte_i[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
            phase_d = PH_EXT;
          end else begin
            len_d = {57'd0, rx_byte_i[6:0]};
            if (rx_byte_i[7]) phase_d = PH_KEY;
            else finish = 1'b1;
          end
        end
        PH_EXT: begin
          len_d = {len_q[55:0], rx_byte_i};
          cnt_d = cnt_q - 4'd1;
          if (cnt_q == 4'd1) begin
            cnt_d = '0;
            if (mask_q) phase_d = PH_KEY;
            else finish = 1'b1;
          end
        end
        PH_KEY: begin
          key_d = {key_q[23:0], rx_byte_i};
          cnt_d = cnt_q + 4'd1;
          if (cnt_q == 4'd3) finish = 1'b1;
        end
        PH_DATA: begin
          koff_d = koff_q + 2'd1;
          rem_d  = rem_dec;
          if (rem_dec == 64'd0) phase_d = PH_HDR0;
          emit = !drop_q;
          res_o.kind = 1'b1;
          res_o.data = rx_byte_i ^ key_byte;
          res_o.fin = fin; res_o.opcode = op; res_o.masked = mask_q;
          res_o.length = len_q;
          res_o.status = ST_OK;
          res_o.last = (rem_dec == 64'd0);
        end
        default: phase_d = PH_HDR0;
      endcase
      if (finish) begin
        status = check(hdr0_q, mask_d, len_d, cfg_i);
        emit   = 1'b1;
        res_o.kind = 1'b0; res_o.data = '0;
        res_o.fin = fin; res_o.opcode = op; res_o.masked = mask_d;
        res_o.length = len_d; res_o.status = status;
        res_o.last = (status != ST_OK) || (len_d == 64'd0);
        koff_d = '0; cnt_d = '0;
        if (len_d == 64'd0) phase_d = PH_HDR0;
        else begin
          phase_d = PH_DATA; rem_d = len_d; drop_d = (status != ST_OK);
        end
      end else begin
        status = ST_OK;
      end
    end else begin
      status = ST_OK;
    end
  end

  assign res_valid_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0; hdr0_q <= '0; mask_q <= 1'b0; cnt_q <= '0;
      len_q <= '0; key_q <= '0; rem_q <= '0; drop_q <= 1'b0; koff_q <= '0;
    end else begin
      phase_q <= phase_d; hdr0_q <= hdr0_d; mask_q <= mask_d; cnt_q <= cnt_d;
      len_q <= len_d; key_q <= key_d; rem_q <= rem_d; drop_q <= drop_d; koff_q <= koff_d;
    end
  end

endmodule

// File: sv/wsfd_queue.sv
// Back end: two-entry result queue that decouples the parser from the receiver.
module wsfd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  input  wsfd_pkg::result_t wr_data_i,
  output logic              wr_ready_o,
  output logic              rd_valid_o,
  output wsfd_pkg::result_t rd_data_o,
  input  logic              rd_ready_i
);
  import wsfd_pkg::*;

  result_t    mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rptr_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0; rptr_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// File: sv/websocket_frame_deframer_unit.sv
// Top level of the WebSocket frame deframer: config registers, parser, result queue.
// Usage:
//   Input channel (in_valid_i/in_ready_o/rx_byte_i) takes one byte of the
//   received frame stream per beat. Output channel (out_valid_o/out_ready_i)
//   delivers header summaries (result_kind 0) and unmasked payload bytes
//   (result_kind 1); rejected or oversized payloads are drained silently.
//   Throughput: one byte per cycle while the receiver keeps up. Each result,
//   whether for the byte that completes a header or for a payload byte, is
//   registered in a two-entry result queue before it reaches the output.
//   in_ready_o is high whenever the queue has room, so the parser stalls only
//   when the receiver holds out_ready_i low long enough to fill the queue.
//   The APB port holds mask_required (0x0), reject_fragments (0x4) and
//   payload_capacity (0x8); write it only while idle. Reads return values.
//   Reset: parser waits for a first header byte, queue empties, registers
//   return to masked required, fragments rejected, capacity 4096.
module websocket_frame_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        fin_flag_o,
  output logic [3:0]  frame_opcode_o,
  output logic        masked_flag_o,
  output logic [63:0] payload_length_o,
  output logic [2:0]  frame_status_o,
  output logic        frame_last_o
);
  import wsfd_pkg::*;

  cfg_t    cfg_q;
  logic    res_valid, q_ready;
  result_t res, out;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register file; addresses beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask_required    <= 1'b1;
      cfg_q.reject_fragments <= 1'b1;
      cfg_q.capacity         <= 32'd4096;
    end else if (wr_en && paddr[1:0] == 2'd0) begin
      unique case (paddr[3:2])
        REG_MASK_REQUIRED: cfg_q.mask_required    <= pwdata[0];
        REG_REJECT_FRAG:   cfg_q.reject_fragments <= pwdata[0];
        REG_CAPACITY:      cfg_q.capacity         <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MASK_REQUIRED: prdata = {31'd0, cfg_q.mask_required};
      REG_REJECT_FRAG:   prdata = {31'd0, cfg_q.reject_fragments};
      REG_CAPACITY:      prdata = cfg_q.capacity;
      default:           prdata = '0;
    endcase
  end

  wsfd_parser u_parser (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .rx_byte_i,
    .cfg_i(cfg_q), .res_valid_o(res_valid), .res_o(res), .res_ready_i(q_ready)
  );

  wsfd_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(res_valid), .wr_data_i(res), .wr_ready_o(q_ready),
    .rd_valid_o(out_valid_o), .rd_data_o(out), .rd_ready_i(out_ready_i)
  );

  assign result_kind_o    = out.kind;
  assign payload_byte_o   = out.data;
  assign fin_flag_o       = out.fin;
  assign frame_opcode_o   = out.opcode;
  assign masked_flag_o    = out.masked;
  assign payload_length_o = out.length;
  assign frame_status_o   = out.status;
  assign frame_last_o     = out.last;

endmodule
